// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the motor fault monitor.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- design/mfm_pkg.sv -----
// Types and constants of the motor fault monitor.
// No dependencies; used by every module of the block.
package mfm_pkg;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int FAULT_W     = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_TIME       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_TIME      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_TICKS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DWELL_TICKS    = 3'd5;

   // register reset values
   localparam logic [15:0] RST_LOW_THRESHOLD  = 16'd1690;
   localparam logic [15:0] RST_HIGH_THRESHOLD = 16'd2027;
   localparam logic [7:0]  RST_LOW_TIME       = 8'd10;
   localparam logic [7:0]  RST_HIGH_TIME      = 8'd4;
   localparam logic [15:0] RST_CLEAR_TICKS    = 16'd1000;
   localparam logic [15:0] RST_DWELL_TICKS    = 16'd6000;

   // fault word bit positions
   localparam int FAULT_OC_BIT     = 0;
   localparam int FAULT_HALL_BIT   = 2;
   localparam int FAULT_UPPER_BIT  = 4;
   localparam int FAULT_LOWER_BIT  = 5;
   localparam int FAULT_MANUAL_BIT = 6;

   // invalid hall codes
   localparam logic [2:0] HALL_ALL_LOW  = 3'b000;
   localparam logic [2:0] HALL_ALL_HIGH = 3'b111;

   typedef struct packed {
      logic [15:0] low_threshold;
      logic [15:0] high_threshold;
      logic [7:0]  low_time;
      logic [7:0]  high_time;
      logic [15:0] clear_ticks;
   } oc_cfg_type;

   typedef struct packed {
      logic fault;
      logic trip;
   } oc_status_type;

   typedef struct packed {
      logic lower_on;
      logic upper_on;
      logic can_count;
   } limit_in_type;

endpackage

// ----- design/mfm_overcurrent.sv -----
// Overcurrent run counters, latched fault and self-clear counter.
// Depends on mfm_pkg.
module mfm_overcurrent #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic signed [15:0]    motor_current,
   input  mfm_pkg::oc_cfg_type   cfg,
   output mfm_pkg::oc_status_type status
);

   logic [COUNTER_WIDTH-1:0] low_cnt_ff, low_cnt_in, low_inc;
   logic [COUNTER_WIDTH-1:0] high_cnt_ff, high_cnt_in, high_inc;
   logic                     fault_ff, fault_in;
   logic [15:0]              clr_cnt_ff, clr_cnt_in, clr_inc;
   logic [16:0]              mag;
   logic                     low_ge, high_ge, low_trip, high_trip, trip, fault_pre;

   always_comb begin
      mag = motor_current[15] ? (17'h10000 - {1'b0, motor_current}) : {1'b0, motor_current};
      low_ge  = mag >= {1'b0, cfg.low_threshold};
      high_ge = mag >= {1'b0, cfg.high_threshold};
      low_inc  = (&low_cnt_ff)  ? low_cnt_ff  : low_cnt_ff  + COUNTER_WIDTH'(1);
      high_inc = (&high_cnt_ff) ? high_cnt_ff : high_cnt_ff + COUNTER_WIDTH'(1);
      low_trip  = low_ge  && (low_inc  > COUNTER_WIDTH'(cfg.low_time));
      high_trip = high_ge && (high_inc > COUNTER_WIDTH'(cfg.high_time));
      trip = low_trip | high_trip;
      low_cnt_in = low_ge ? low_inc : '0;
      if (!low_ge) begin
         high_cnt_in = '0;
      end else if (high_ge) begin
         high_cnt_in = high_inc;
      end else begin
         high_cnt_in = high_cnt_ff;
      end
      fault_pre = fault_ff | trip;
      clr_inc   = (&clr_cnt_ff) ? clr_cnt_ff : clr_cnt_ff + 16'd1;
      if (fault_pre) begin
         if (clr_inc >= cfg.clear_ticks) begin
            fault_in   = 1'b0;
            clr_cnt_in = '0;
         end else begin
            fault_in   = 1'b1;
            clr_cnt_in = clr_inc;
         end
      end else begin
         fault_in   = 1'b0;
         clr_cnt_in = clr_cnt_ff;
      end
      status.fault = fault_in;
      status.trip  = trip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_cnt_ff  <= '0;
         high_cnt_ff <= '0;
         fault_ff    <= 1'b0;
         clr_cnt_ff  <= '0;
      end else if (step) begin
         low_cnt_ff  <= low_cnt_in;
         high_cnt_ff <= high_cnt_in;
         fault_ff    <= fault_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

endmodule

// ----- design/mfm_limit.sv -----
// Limit-switch dwell counters and the saturating total of counted cycles.
// Depends on mfm_pkg.
module mfm_limit #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  mfm_pkg::limit_in_type sw,
   input  logic [15:0]          dwell_ticks,
   output logic [15:0]          cycles_done
);

   logic [15:0]              lower_dwell_ff, lower_dwell_in, lower_pre;
   logic [15:0]              upper_dwell_ff, upper_dwell_in, upper_pre;
   logic [COUNTER_WIDTH-1:0] total_ff, total_in, total_mid;
   logic [COUNTER_WIDTH+15:0] total_ext;
   logic                     lower_hit, upper_hit;

   always_comb begin
      lower_pre = lower_dwell_ff;
      if (sw.lower_on && !(&lower_dwell_ff)) begin
         lower_pre = lower_dwell_ff + 16'd1;
      end
      upper_pre = upper_dwell_ff;
      if (sw.upper_on && !(&upper_dwell_ff)) begin
         upper_pre = upper_dwell_ff + 16'd1;
      end
      lower_hit = lower_pre >= dwell_ticks;
      upper_hit = upper_pre >= dwell_ticks;
      lower_dwell_in = lower_hit ? 16'd0 : lower_pre;
      upper_dwell_in = upper_hit ? 16'd0 : upper_pre;
      total_mid = total_ff;
      if (lower_hit && sw.can_count && !(&total_ff)) begin
         total_mid = total_ff + COUNTER_WIDTH'(1);
      end
      total_in = total_mid;
      if (upper_hit && sw.can_count && !(&total_mid)) begin
         total_in = total_mid + COUNTER_WIDTH'(1);
      end
      total_ext   = {16'd0, total_in};
      cycles_done = total_ext[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_dwell_ff <= '0;
         upper_dwell_ff <= '0;
         total_ff       <= '0;
      end else if (step) begin
         lower_dwell_ff <= lower_dwell_in;
         upper_dwell_ff <= upper_dwell_in;
         total_ff       <= total_in;
      end
   end

endmodule

// ----- design/motor_fault_monitor_unit.sv -----
// Top level of the motor fault monitor: register file, input and result stages.
// Depends on mfm_pkg, mfm_overcurrent, mfm_limit and assert_macros.svh.
//
// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  req_tdata  one control tick
// rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata  fault word and status
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One tick per cycle unless stalled; rsp_tvalid rises as it enters the result register.
// The per-tick counter update sits between the input register and the result register.
// Reset is synchronous; no clearing pass, the block takes ticks on the next cycle.
// A stalled result holds the result register; the input register still takes one more.
`include "assert_macros.svh"
module motor_fault_monitor_unit #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] manual_switch, [1] lower_switch, [2] upper_switch, [18:3] motor_current,
   // [21:19] hall_state, [22] motor_stopped, [23] position_known
   input  logic [mfm_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] fault_code, [7] stop_request, [8] lower_limit, [9] upper_limit,
   // [25:10] cycles_done, [31:26] zero
   output logic [mfm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [mfm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [15:0] low_threshold_ff, high_threshold_ff, clear_ticks_ff, dwell_ticks_ff;
   logic [7:0]  low_time_ff, high_time_ff;

   logic                           in_valid_ff, in_valid_in;
   logic [mfm_pkg::REQ_DATA_W-1:0] in_data_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mfm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                   advance, move, req_accept;
   logic                   manual_on, hall_bad;
   logic signed [15:0]     motor_current;
   logic [2:0]             hall_state;
   logic [mfm_pkg::FAULT_W-1:0] fault_code;
   logic                   stop_request;
   logic [15:0]            cycles_done;

   logic                   res_hall, res_stop;
   logic [1:0]             lim_flags, lim_bits;

   mfm_pkg::oc_cfg_type    oc_cfg;
   mfm_pkg::oc_status_type oc_status;
   mfm_pkg::limit_in_type  limit_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff  <= mfm_pkg::RST_LOW_THRESHOLD;
         high_threshold_ff <= mfm_pkg::RST_HIGH_THRESHOLD;
         low_time_ff       <= mfm_pkg::RST_LOW_TIME;
         high_time_ff      <= mfm_pkg::RST_HIGH_TIME;
         clear_ticks_ff    <= mfm_pkg::RST_CLEAR_TICKS;
         dwell_ticks_ff    <= mfm_pkg::RST_DWELL_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            mfm_pkg::CSR_LOW_THRESHOLD: begin
               low_threshold_ff <= csr_wdata;
            end
            mfm_pkg::CSR_HIGH_THRESHOLD: begin
               high_threshold_ff <= csr_wdata;
            end
            mfm_pkg::CSR_LOW_TIME: begin
               low_time_ff <= csr_wdata[7:0];
            end
            mfm_pkg::CSR_HIGH_TIME: begin
               high_time_ff <= csr_wdata[7:0];
            end
            mfm_pkg::CSR_CLEAR_TICKS: begin
               clear_ticks_ff <= csr_wdata;
            end
            mfm_pkg::CSR_DWELL_TICKS: begin
               dwell_ticks_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // handshake and stage control
   always_comb begin
      advance      = !rsp_valid_ff || rsp_tready;
      move         = in_valid_ff && advance;
      req_tready   = !reset && (!in_valid_ff || advance);
      req_accept   = req_tvalid && req_tready;
      in_valid_in  = req_accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
      rsp_valid_in = move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_tdata;
      end
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // field decode of the held tick
   always_comb begin
      manual_on          = !in_data_ff[0];
      limit_in.lower_on  = !in_data_ff[1];
      limit_in.upper_on  = !in_data_ff[2];
      motor_current      = $signed(in_data_ff[18:3]);
      hall_state         = in_data_ff[21:19];
      limit_in.can_count = in_data_ff[22] && in_data_ff[23];
      hall_bad           = hall_state inside {mfm_pkg::HALL_ALL_LOW, mfm_pkg::HALL_ALL_HIGH};
      oc_cfg.low_threshold  = low_threshold_ff;
      oc_cfg.high_threshold = high_threshold_ff;
      oc_cfg.low_time       = low_time_ff;
      oc_cfg.high_time      = high_time_ff;
      oc_cfg.clear_ticks    = clear_ticks_ff;
   end

   mfm_overcurrent #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_overcurrent (
      .clock         (clock),
      .reset         (reset),
      .step          (move),
      .motor_current (motor_current),
      .cfg           (oc_cfg),
      .status        (oc_status)
   );

   mfm_limit #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_limit (
      .clock       (clock),
      .reset       (reset),
      .step        (move),
      .sw          (limit_in),
      .dwell_ticks (dwell_ticks_ff),
      .cycles_done (cycles_done)
   );

   // result assembly
   always_comb begin
      fault_code = '0;
      fault_code[mfm_pkg::FAULT_OC_BIT]     = oc_status.fault;
      fault_code[mfm_pkg::FAULT_HALL_BIT]   = hall_bad;
      fault_code[mfm_pkg::FAULT_UPPER_BIT]  = limit_in.upper_on;
      fault_code[mfm_pkg::FAULT_LOWER_BIT]  = limit_in.lower_on;
      fault_code[mfm_pkg::FAULT_MANUAL_BIT] = manual_on;
      stop_request = oc_status.trip || hall_bad;
      rsp_data_in  = {6'd0, cycles_done, limit_in.upper_on, limit_in.lower_on,
                      stop_request, fault_code};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // fields of the result register seen by the checks
   always_comb begin
      res_hall  = rsp_valid_ff && rsp_data_ff[mfm_pkg::FAULT_HALL_BIT];
      res_stop  = rsp_data_ff[mfm_pkg::FAULT_W];
      lim_flags = rsp_data_ff[mfm_pkg::FAULT_W+2:mfm_pkg::FAULT_W+1];
      lim_bits  = {rsp_data_ff[mfm_pkg::FAULT_UPPER_BIT], rsp_data_ff[mfm_pkg::FAULT_LOWER_BIT]};
   end

   // a hall fault always comes with a stop request
   `ASSERT_PROP(a_hall_stop, clock, reset, res_hall |-> res_stop, "hall fault without stop")
   // limit flags agree with the fault word
   `ASSERT_NEVER(a_limits, clock, reset, rsp_tvalid && lim_flags != lim_bits, "limit flag mismatch")
   // a held tick blocked by a stalled result is not dropped
   `ASSERT_PROP(a_tick_kept, clock, reset, in_valid_ff && !advance |=> in_valid_ff, "tick lost")

endmodule
